[hdl/sfr_pkg.sv]
package sfr_pkg;

	// Reset values of the configuration registers
	localparam logic [7:0]  SYNC_FIRST_RST    = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND_RST   = 8'h55;
	localparam logic [19:0] TIMEOUT_TICKS_RST = 20'd1000;
	localparam logic [10:0] PAYLOAD_LIMIT_RST = 11'd1024;

	// Parameter defaults
	localparam int MAX_PAYLOAD_DEF = 1024;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LIMIT = 2'd3;

	// Result kinds
	localparam logic [2:0] KIND_PAYLOAD = 3'd0;
	localparam logic [2:0] KIND_GOOD    = 3'd1;
	localparam logic [2:0] KIND_CRC_ERR = 3'd2;
	localparam logic [2:0] KIND_TOO_LONG = 3'd3;
	localparam logic [2:0] KIND_TIMEOUT = 3'd4;

	localparam logic [15:0] CRC_POLY       = 16'h1021;
	localparam logic [16:0] FRAME_OVERHEAD = 17'd8;

	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [19:0] timeout_ticks;
		logic [10:0] payload_limit;
	} cfg_t;

	// Classified input beat
	typedef struct packed {
		logic       is_tick;
		logic [7:0] data;
		logic       first_hit;
		logic       second_hit;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [7:0]  payload_byte;
		logic [9:0]  byte_index;
		logic [7:0]  frame_type;
		logic [7:0]  frame_dest;
		logic [15:0] payload_length;
		logic [15:0] total_length;
		logic        end_of_frame;
	} res_t;

	// CRC-16, poly 0x1021, MSB first, one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[hdl/sfr_stream_if.sv]
interface sfr_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] rx_byte;

	modport source(output valid, mode, rx_byte, input ready);
	modport sink(input valid, mode, rx_byte, output ready);
endinterface

interface sfr_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [7:0]  payload_byte;
	logic [9:0]  byte_index;
	logic [7:0]  frame_type;
	logic [7:0]  frame_dest;
	logic [15:0] payload_length;
	logic [15:0] total_length;
	logic        end_of_frame;

	modport source(output valid, result_kind, payload_byte, byte_index, frame_type,
		frame_dest, payload_length, total_length, end_of_frame, input ready);
	modport sink(input valid, result_kind, payload_byte, byte_index, frame_type,
		frame_dest, payload_length, total_length, end_of_frame, output ready);
endinterface

[hdl/sync_frame_receiver_crc16.sv]
// Sync frame receiver with CRC-16 (poly 0x1021, init 0) check.
// item channel: one beat per received byte (mode 0) or per time tick (mode 1).
// result channel: one beat per payload byte as it arrives, plus one status
// beat (good, CRC error, length too long, timeout) that ends each frame;
// beats that cause nothing produce no result.
// Config: wr_en / wr_index / wr_data write sync_first, sync_second,
// timeout_ticks and payload_limit; write only while the block is idle.
// Path: an item beat is written into the input queue, and the frame state
// machine step pops it and loads the output register; a stall in the back
// end can hold the beat in the queue.
// Throughput: one item per cycle while result.ready stays high, set by the
// combinational byte CRC update and state machine step in the back end.
// Stall: while result.ready is low the output register holds its beat and
// the input queue keeps taking items until it fills, then item.ready drops.
// Reset: arst_n clears the queue, the output register and the frame state,
// returns to hunting the first sync byte and loads the default registers.
module sync_frame_receiver_crc16 #(
	parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF,
	parameter int QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	sfr_in_if.sink                           item,
	sfr_out_if.source                        result,
	input  logic                             wr_en,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0]   wr_data
);
	import sfr_pkg::*;

	cfg_t    cfg_q;
	q_stat_t q_stat;
	logic    push;
	logic    pop;
	item_t   push_item;
	item_t   pop_item;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first    <= SYNC_FIRST_RST;
			cfg_q.sync_second   <= SYNC_SECOND_RST;
			cfg_q.timeout_ticks <= TIMEOUT_TICKS_RST;
			cfg_q.payload_limit <= PAYLOAD_LIMIT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SYNC_FIRST:    cfg_q.sync_first    <= wr_data[7:0];
				REG_SYNC_SECOND:   cfg_q.sync_second   <= wr_data[7:0];
				REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= wr_data[19:0];
				REG_PAYLOAD_LIMIT: cfg_q.payload_limit <= wr_data[10:0];
				default: ;
			endcase
		end
	end

	sfr_front u_front (
		.item      (item),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	sfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_stat    (q_stat)
	);

	sfr_back #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_stat   (q_stat),
		.pop_item (pop_item),
		.pop      (pop),
		.result   (result)
	);

`ifndef SYNTHESIS
	// Back end never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// Status beats and only status beats end a frame
	a_eof_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.end_of_frame == (result.result_kind != KIND_PAYLOAD)))
		else $error("end_of_frame does not match result kind");

	// A good frame reports length plus overhead
	a_good_total: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.result_kind == KIND_GOOD)
		|-> (result.total_length == result.payload_length + 16'd8))
		else $error("total length wrong on good frame");
`endif

endmodule

[hdl/sfr_front.sv]
module sfr_front (
	sfr_in_if.sink          item,
	input  sfr_pkg::cfg_t    cfg,
	input  sfr_pkg::q_stat_t q_stat,
	output logic             push,
	output sfr_pkg::item_t   push_item
);
	import sfr_pkg::*;

	// Take a beat whenever the queue has room
	assign item.ready = !q_stat.full;
	assign push       = item.valid && !q_stat.full;

	// Classify: tick or byte, and sync matches up front
	always_comb begin
		push_item.is_tick    = item.mode;
		push_item.data       = item.rx_byte;
		push_item.first_hit  = (item.rx_byte == cfg.sync_first);
		push_item.second_hit = (item.rx_byte == cfg.sync_second);
	end

endmodule

[hdl/sfr_queue.sv]
module sfr_queue #(
	parameter int DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sfr_pkg::item_t   push_item,
	input  logic             pop,
	output sfr_pkg::item_t   pop_item,
	output sfr_pkg::q_stat_t q_stat
);
	import sfr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign q_stat.full  = (cnt_q == FULL_CNT);
	assign q_stat.empty = (cnt_q == '0);
	assign pop_item     = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hdl/sfr_back.sv]
module sfr_back #(
	parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sfr_pkg::cfg_t    cfg,
	input  sfr_pkg::q_stat_t q_stat,
	input  sfr_pkg::item_t   pop_item,
	output logic             pop,
	sfr_out_if.source        result
);
	import sfr_pkg::*;

	localparam logic [2:0] PH_SYNC1 = 3'd0;
	localparam logic [2:0] PH_SYNC2 = 3'd1;
	localparam logic [2:0] PH_TYPE  = 3'd2;
	localparam logic [2:0] PH_DEST  = 3'd3;
	localparam logic [2:0] PH_LENLO = 3'd4;
	localparam logic [2:0] PH_LENHI = 3'd5;
	localparam logic [2:0] PH_DATA  = 3'd6;
	localparam logic [2:0] PH_CRC   = 3'd7;

	localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

	logic [2:0]  phase_q, phase_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  dest_q, dest_d;
	logic [15:0] length_q, length_d;
	logic [10:0] bytes_q, bytes_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_low_q, crc_low_d;
	logic [19:0] ticks_q, ticks_d;

	logic        res_valid_q;
	res_t        res_q, res_d;
	logic        emit;

	logic [20:0] tick_next;
	logic [15:0] limit;
	logic [15:0] crc_upd;
	logic [10:0] bytes_inc;
	logic [16:0] total;

	// Pop when the output register is free or being drained
	assign pop = !q_stat.empty && (!res_valid_q || result.ready);

	assign tick_next = {1'b0, ticks_q} + 21'd1;
	assign limit     = ({5'b0, cfg.payload_limit} > MAX_LEN) ? MAX_LEN
		: {5'b0, cfg.payload_limit};
	assign crc_upd   = crc_byte(crc_q, pop_item.data);
	assign bytes_inc = bytes_q + 11'd1;
	assign total     = {1'b0, length_q} + FRAME_OVERHEAD;

	// Frame state machine, one beat per cycle while pop is high
	always_comb begin
		phase_d   = phase_q;
		type_d    = type_q;
		dest_d    = dest_q;
		length_d  = length_q;
		bytes_d   = bytes_q;
		crc_d     = crc_q;
		crc_low_d = crc_low_q;
		ticks_d   = ticks_q;
		emit      = 1'b0;
		res_d.result_kind  = KIND_PAYLOAD;
		res_d.payload_byte = '0;
		res_d.byte_index   = '0;
		res_d.total_length = '0;
		res_d.end_of_frame = 1'b0;

		if (pop_item.is_tick) begin
			if (tick_next > {1'b0, cfg.timeout_ticks}) begin
				emit               = 1'b1;
				res_d.result_kind  = KIND_TIMEOUT;
				res_d.end_of_frame = 1'b1;
				phase_d            = PH_SYNC1;
				ticks_d            = '0;
			end else begin
				ticks_d = tick_next[19:0];
			end
		end else begin
			unique case (phase_q)
				PH_SYNC1: begin
					if (pop_item.first_hit) begin
						phase_d = PH_SYNC2;
					end
				end
				PH_SYNC2: begin
					if (pop_item.second_hit) begin
						phase_d = PH_TYPE;
						crc_d   = '0;
					end else begin
						phase_d = PH_SYNC1;
					end
				end
				PH_TYPE: begin
					type_d  = pop_item.data;
					crc_d   = crc_upd;
					phase_d = PH_DEST;
				end
				PH_DEST: begin
					dest_d  = pop_item.data;
					crc_d   = crc_upd;
					phase_d = PH_LENLO;
				end
				PH_LENLO: begin
					length_d = {8'h00, pop_item.data};
					crc_d    = crc_upd;
					phase_d  = PH_LENHI;
				end
				PH_LENHI: begin
					length_d = {pop_item.data, length_q[7:0]};
					crc_d    = crc_upd;
					bytes_d  = '0;
					if (length_d > limit) begin
						emit               = 1'b1;
						res_d.result_kind  = KIND_TOO_LONG;
						res_d.end_of_frame = 1'b1;
						phase_d            = PH_SYNC1;
						ticks_d            = '0;
					end else begin
						phase_d = (length_d == '0) ? PH_CRC : PH_DATA;
					end
				end
				PH_DATA: begin
					crc_d   = crc_upd;
					bytes_d = bytes_inc;
					if ({5'b0, bytes_inc} >= length_q) begin
						phase_d = PH_CRC;
					end
					emit               = 1'b1;
					res_d.result_kind  = KIND_PAYLOAD;
					res_d.payload_byte = pop_item.data;
					res_d.byte_index   = bytes_q[9:0];
				end
				PH_CRC: begin
					if ({5'b0, bytes_q} == length_q) begin
						crc_low_d = pop_item.data;
						bytes_d   = bytes_inc;
					end else begin
						emit               = 1'b1;
						res_d.end_of_frame = 1'b1;
						if ({pop_item.data, crc_low_q} == crc_q) begin
							res_d.result_kind  = KIND_GOOD;
							res_d.total_length = total[16] ? 16'hFFFF : total[15:0];
						end else begin
							res_d.result_kind = KIND_CRC_ERR;
						end
						phase_d = PH_SYNC1;
						ticks_d = '0;
					end
				end
				default: begin
					phase_d = PH_SYNC1;
				end
			endcase
		end

		res_d.frame_type     = type_d;
		res_d.frame_dest     = dest_d;
		res_d.payload_length = length_d;
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SYNC1;
			type_q    <= '0;
			dest_q    <= '0;
			length_q  <= '0;
			bytes_q   <= '0;
			crc_q     <= '0;
			crc_low_q <= '0;
			ticks_q   <= '0;
		end else if (pop) begin
			phase_q   <= phase_d;
			type_q    <= type_d;
			dest_q    <= dest_d;
			length_q  <= length_d;
			bytes_q   <= bytes_d;
			crc_q     <= crc_d;
			crc_low_q <= crc_low_d;
			ticks_q   <= ticks_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= emit;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			res_q <= res_d;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.result_kind    = res_q.result_kind;
	assign result.payload_byte   = res_q.payload_byte;
	assign result.byte_index     = res_q.byte_index;
	assign result.frame_type     = res_q.frame_type;
	assign result.frame_dest     = res_q.frame_dest;
	assign result.payload_length = res_q.payload_length;
	assign result.total_length   = res_q.total_length;
	assign result.end_of_frame   = res_q.end_of_frame;

endmodule
